>>> hdl/spsg_pkg.sv
// ----------------------------------------------------------------------------
// spsg_pkg
// shared types and constants of the scanline polygon span generator
// ----------------------------------------------------------------------------
package spsg_pkg;

  localparam int MaxResults = 16;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLOSE = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_DROP  = 2'd1,
    KIND_SPAN  = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DISP = 6'b000010,
    ST_AGE  = 6'b000100,
    ST_BKT  = 6'b001000,
    ST_SEL  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

endpackage

>>> hdl/spsg_ram.sv
// ----------------------------------------------------------------------------
// spsg_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module spsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/scanline_polygon_span_generator.sv
// ----------------------------------------------------------------------------
// scanline_polygon_span_generator
// scanline polygon fill with an active edge table held in ram
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel, opcode in tuser: add an edge to the
// bucket, close the scanline, or clear and restart. Results leave on m_axis,
// kind in tuser, tlast on the final result of a request. Add, clear and the
// unused opcode give one result each, decoded in the dispatch state.
// Closing a scanline with A active and B bucket edges ages and merges the
// table through the active edge ram, then makes one scan of the N resulting
// edges per span endpoint to pick the edges in x order through the single
// ram read port.
// One request is handled at a time; s_axis_tready_o is high while idle, and
// a request is taken while the previous result still waits in the output
// register. When the receiver stalls, the block holds its result and stops.
// After reset both tables are empty and the first close does not age edges;
// no clearing pass is needed since only entries below the counts are read.
// ----------------------------------------------------------------------------
module scanline_polygon_span_generator #(
  parameter int MAX_EDGES  = 32,
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16,
  localparam int XB  = COORD_BITS + FRAC_BITS,
  localparam int ID  = 2 * XB + COORD_BITS + 1,
  localparam int ITW = ((ID + 7) / 8) * 8,
  localparam int OD  = 3 * COORD_BITS,
  localparam int OTW = ((OD + 7) / 8) * 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  // x_start, y_last, inverse_slope
  input  logic [ITW-1:0] s_axis_tdata_i,
  // opcode
  input  logic [1:0]     s_axis_tuser_i,
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  // span_y, span_x_left, span_x_right
  output logic [OTW-1:0] m_axis_tdata_o,
  // kind
  output logic [1:0]     m_axis_tuser_o,
  output logic           m_axis_tlast_o
);

  localparam int IW  = $clog2(MAX_EDGES);
  localparam int CW  = $clog2(MAX_EDGES + 1);
  localparam int PW  = $clog2(spsg_pkg::MaxResults + 1);
  localparam int C   = COORD_BITS;
  localparam int AW  = 2 * XB + C + 2;
  localparam logic [CW:0] MaxCnt = (CW + 1)'(MAX_EDGES);
  localparam logic [C-1:0] CoordMax = {C{1'b1}};
  localparam logic signed [XB+1:0] CeilAdd = (XB + 2)'((1 << FRAC_BITS) - 1);

  spsg_pkg::state_e state_q, state_d;
  logic [CW-1:0] act_cnt_q, act_cnt_d, bkt_cnt_q, bkt_cnt_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d, wr_idx_q, wr_idx_d;
  logic [C-1:0]  cur_q, cur_d;
  logic          first_q, first_d, pend_q, pend_d;
  logic          have_prev_q, have_prev_d, found_q, found_d, right_q, right_d;
  logic [PW-1:0] pi_q, pi_d, np_q, np_d;
  logic          out_v_q, out_v_d, res_last_q, res_last_d;

  spsg_pkg::op_e     op_q;
  logic [XB-1:0]     xs_q;
  logic [C-1:0]      ly_q;
  logic [XB:0]       sl_q;
  logic [IW-1:0]     dat_idx_q, dat_idx_d;
  logic signed [XB:0] best_x_q, best_x_d, prev_x_q, prev_x_d;
  logic [IW-1:0]     best_i_q, best_i_d, prev_i_q, prev_i_d;
  logic [C-1:0]      left_q, left_d;
  spsg_pkg::kind_e   res_kind_q, res_kind_d, out_kind_q;
  logic [C-1:0]      res_y_q, res_y_d, res_xl_q, res_xl_d, res_xr_q, res_xr_d;
  logic [C-1:0]      out_y_q, out_xl_q, out_xr_q;
  logic              out_last_q;
  logic              load_out;

  logic            act_we, bkt_we;
  logic [IW-1:0]   act_waddr, act_raddr, bkt_raddr;
  logic [AW-1:0]   act_wdata, act_rdata;
  logic [ID-1:0]   bkt_rdata;

  logic signed [XB:0] a_x, a_sl, a_sum_sat;
  logic [C-1:0]       a_ly;
  logic signed [XB+1:0] a_sum;
  logic               qual, better;
  logic [CW-1:0]      half;
  logic [CW:0]        total;

  function automatic logic [C-1:0] px_ceil(input logic signed [XB:0] x);
    logic signed [XB+1:0] s;
    s = $signed({x[XB], x}) + CeilAdd;
    if (s[XB+1]) begin
      return '0;
    end else if (s[XB:FRAC_BITS+C] != '0) begin
      return CoordMax;
    end else begin
      return s[FRAC_BITS+C-1:FRAC_BITS];
    end
  endfunction

  function automatic logic [C-1:0] px_floor(input logic signed [XB:0] x);
    if (x[XB]) begin
      return '0;
    end else begin
      return x[XB-1:FRAC_BITS];
    end
  endfunction

  spsg_ram #(.WIDTH(AW), .DEPTH(MAX_EDGES)) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (act_we),
    .waddr_i (act_waddr),
    .wdata_i (act_wdata),
    .raddr_i (act_raddr),
    .rdata_o (act_rdata)
  );

  spsg_ram #(.WIDTH(ID), .DEPTH(MAX_EDGES)) u_bkt_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (bkt_cnt_q[IW-1:0]),
    .wdata_i ({sl_q, ly_q, xs_q}),
    .raddr_i (bkt_raddr),
    .rdata_o (bkt_rdata)
  );

  // active word: x, last y, slope from the lowest bit up
  assign a_x  = $signed(act_rdata[XB:0]);
  assign a_ly = act_rdata[XB+C:XB+1];
  assign a_sl = $signed(act_rdata[AW-1:XB+C+1]);
  assign a_sum = $signed({a_x[XB], a_x}) + $signed({a_sl[XB], a_sl});

  always_comb begin
    if (a_sum[XB+1] != a_sum[XB]) begin
      a_sum_sat = a_sum[XB+1] ? {1'b1, {XB{1'b0}}} : {1'b0, {XB{1'b1}}};
    end else begin
      a_sum_sat = a_sum[XB:0];
    end
  end

  assign qual = !have_prev_q || (a_x > prev_x_q) ||
                ((a_x == prev_x_q) && (dat_idx_q > prev_i_q));
  assign better = !found_q || (a_x < best_x_q);
  assign total = {1'b0, act_cnt_q} + {1'b0, bkt_cnt_q};
  assign half = wr_idx_q >> 1;

  assign act_raddr = rd_idx_q[IW-1:0];
  assign bkt_raddr = rd_idx_q[IW-1:0];
  assign act_waddr = wr_idx_q[IW-1:0];

  always_comb begin
    state_d     = state_q;
    act_cnt_d   = act_cnt_q;
    bkt_cnt_d   = bkt_cnt_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    cur_d       = cur_q;
    first_d     = first_q;
    pend_d      = 1'b0;
    have_prev_d = have_prev_q;
    found_d     = found_q;
    right_d     = right_q;
    pi_d        = pi_q;
    np_d        = np_q;
    res_last_d  = res_last_q;
    dat_idx_d   = dat_idx_q;
    best_x_d    = best_x_q;
    best_i_d    = best_i_q;
    prev_x_d    = prev_x_q;
    prev_i_d    = prev_i_q;
    left_d      = left_q;
    res_kind_d  = res_kind_q;
    res_y_d     = res_y_q;
    res_xl_d    = res_xl_q;
    res_xr_d    = res_xr_q;
    act_we      = 1'b0;
    act_wdata   = '0;
    bkt_we      = 1'b0;
    load_out    = 1'b0;
    out_v_d     = out_v_q && !m_axis_tready_i;

    unique case (state_q)
      spsg_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = spsg_pkg::ST_DISP;
        end
      end
      spsg_pkg::ST_DISP: begin
        res_kind_d = spsg_pkg::KIND_ACK;
        res_y_d    = '0;
        res_xl_d   = '0;
        res_xr_d   = '0;
        res_last_d = 1'b1;
        state_d    = spsg_pkg::ST_EMIT;
        rd_idx_d   = '0;
        wr_idx_d   = '0;
        unique case (op_q)
          spsg_pkg::OP_ADD: begin
            if (total >= MaxCnt) begin
              res_kind_d = spsg_pkg::KIND_DROP;
            end else begin
              bkt_we    = 1'b1;
              bkt_cnt_d = bkt_cnt_q + 1'b1;
            end
          end
          spsg_pkg::OP_CLOSE: begin
            if (first_q) begin
              cur_d   = cur_q + 1'b1;
              state_d = spsg_pkg::ST_AGE;
            end else begin
              state_d = spsg_pkg::ST_BKT;
            end
          end
          spsg_pkg::OP_CLEAR: begin
            act_cnt_d = '0;
            bkt_cnt_d = '0;
            cur_d     = '0;
            first_d   = 1'b0;
          end
          default: begin
          end
        endcase
      end
      spsg_pkg::ST_AGE: begin
        if (rd_idx_q < act_cnt_q) begin
          pend_d   = 1'b1;
          rd_idx_d = rd_idx_q + 1'b1;
        end else if (!pend_q) begin
          rd_idx_d = '0;
          state_d  = spsg_pkg::ST_BKT;
        end
        if (pend_q && (a_ly != cur_q)) begin
          act_we    = 1'b1;
          act_wdata = {a_sl, a_ly, a_sum_sat};
          wr_idx_d  = wr_idx_q + 1'b1;
        end
      end
      spsg_pkg::ST_BKT: begin
        if (rd_idx_q < bkt_cnt_q) begin
          pend_d   = 1'b1;
          rd_idx_d = rd_idx_q + 1'b1;
        end else if (!pend_q) begin
          act_cnt_d   = wr_idx_q;
          bkt_cnt_d   = '0;
          first_d     = 1'b1;
          rd_idx_d    = '0;
          have_prev_d = 1'b0;
          found_d     = 1'b0;
          right_d     = 1'b0;
          pi_d        = '0;
          if (32'(half) > 32'(spsg_pkg::MaxResults)) begin
            np_d = PW'(spsg_pkg::MaxResults);
          end else begin
            np_d = PW'(half);
          end
          if (half == '0) begin
            res_kind_d = spsg_pkg::KIND_EMPTY;
            res_y_d    = cur_q;
            res_xl_d   = '0;
            res_xr_d   = '0;
            res_last_d = 1'b1;
            state_d    = spsg_pkg::ST_EMIT;
          end else begin
            state_d = spsg_pkg::ST_SEL;
          end
        end
        if (pend_q) begin
          act_we    = 1'b1;
          act_wdata = {bkt_rdata[ID-1:XB+C], bkt_rdata[XB+C-1:XB],
                       1'b0, bkt_rdata[XB-1:0]};
          wr_idx_d  = wr_idx_q + 1'b1;
        end
      end
      spsg_pkg::ST_SEL: begin
        if (rd_idx_q < act_cnt_q) begin
          pend_d    = 1'b1;
          dat_idx_d = rd_idx_q[IW-1:0];
          rd_idx_d  = rd_idx_q + 1'b1;
        end else if (!pend_q) begin
          prev_x_d    = best_x_q;
          prev_i_d    = best_i_q;
          have_prev_d = 1'b1;
          found_d     = 1'b0;
          rd_idx_d    = '0;
          if (!right_q) begin
            left_d  = px_ceil(best_x_q);
            right_d = 1'b1;
          end else begin
            right_d    = 1'b0;
            res_kind_d = spsg_pkg::KIND_SPAN;
            res_y_d    = cur_q;
            res_xl_d   = left_q;
            res_xr_d   = px_floor(best_x_q);
            res_last_d = (pi_q + 1'b1) == np_q;
            state_d    = spsg_pkg::ST_EMIT;
          end
        end
        if (pend_q && qual && better) begin
          found_d  = 1'b1;
          best_x_d = a_x;
          best_i_d = dat_idx_q;
        end
      end
      spsg_pkg::ST_EMIT: begin
        if (!out_v_q || m_axis_tready_i) begin
          load_out = 1'b1;
          out_v_d  = 1'b1;
          if (res_last_q) begin
            state_d = spsg_pkg::ST_IDLE;
          end else begin
            pi_d    = pi_q + 1'b1;
            state_d = spsg_pkg::ST_SEL;
          end
        end
      end
      default: begin
        state_d = spsg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spsg_pkg::ST_IDLE;
      act_cnt_q   <= '0;
      bkt_cnt_q   <= '0;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      cur_q       <= '0;
      first_q     <= 1'b0;
      pend_q      <= 1'b0;
      have_prev_q <= 1'b0;
      found_q     <= 1'b0;
      right_q     <= 1'b0;
      pi_q        <= '0;
      np_q        <= '0;
      out_v_q     <= 1'b0;
      res_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      act_cnt_q   <= act_cnt_d;
      bkt_cnt_q   <= bkt_cnt_d;
      rd_idx_q    <= rd_idx_d;
      wr_idx_q    <= wr_idx_d;
      cur_q       <= cur_d;
      first_q     <= first_d;
      pend_q      <= pend_d;
      have_prev_q <= have_prev_d;
      found_q     <= found_d;
      right_q     <= right_d;
      pi_q        <= pi_d;
      np_q        <= np_d;
      out_v_q     <= out_v_d;
      res_last_q  <= res_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      op_q <= spsg_pkg::op_e'(s_axis_tuser_i);
      xs_q <= s_axis_tdata_i[XB-1:0];
      ly_q <= s_axis_tdata_i[XB+C-1:XB];
      sl_q <= s_axis_tdata_i[ID-1:XB+C];
    end
    dat_idx_q  <= dat_idx_d;
    best_x_q   <= best_x_d;
    best_i_q   <= best_i_d;
    prev_x_q   <= prev_x_d;
    prev_i_q   <= prev_i_d;
    left_q     <= left_d;
    res_kind_q <= res_kind_d;
    res_y_q    <= res_y_d;
    res_xl_q   <= res_xl_d;
    res_xr_q   <= res_xr_d;
    if (load_out) begin
      out_kind_q <= res_kind_q;
      out_y_q    <= res_y_q;
      out_xl_q   <= res_xl_q;
      out_xr_q   <= res_xr_q;
      out_last_q <= res_last_q;
    end
  end

  assign s_axis_tready_o = (state_q == spsg_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = OTW'({out_xr_q, out_xl_q, out_y_q});
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= MaxCnt)
    else $error("edge counts exceed table size");

  a_wr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_we |-> (wr_idx_q < MaxCnt[CW-1:0] || MaxCnt[CW]))
    else $error("active table write past its depth");

  a_sel_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spsg_pkg::ST_SEL) |-> (np_q != '0 && pi_q < np_q))
    else $error("span selection without a pair left");

endmodule
